/* design/sawarq_pkg.sv */
// Shared types and constants of the stop-and-wait ARQ sender.
package sawarq_pkg;

  // Frame limits
  localparam int MAX_PAYLOAD = 64;
  localparam int SEQ_BITS    = 16;
  localparam int LEN_W       = 7;
  localparam int CHECK_W     = 8;
  localparam int RETRY_W     = 8;
  localparam int CTRL_W      = 3;
  localparam int OP_W        = 2;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = RETRY_W'(15);

  // Operation codes of an input word
  localparam logic [OP_W-1:0] OP_PAYLOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMER   = 2'd2;

  // Frame control codes
  localparam logic [CTRL_W-1:0] CTRL_DATA = 3'd4;
  localparam logic [CTRL_W-1:0] CTRL_ACK  = 3'd5;
  localparam logic [CTRL_W-1:0] CTRL_NAK  = 3'd6;

  typedef enum logic [1:0] {
    ACT_SEND      = 2'd0,
    ACT_DELIVERED = 2'd1,
    ACT_RETRANSMIT = 2'd2,
    ACT_GIVE_UP   = 2'd3
  } action_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [7:0]          payload_byte;
    logic                last_of_message;
    logic [SEQ_BITS-1:0] ack_sequence;
    logic [CTRL_W-1:0]   ack_control;
  } item_word_t;

  typedef struct packed {
    action_t             action;
    logic [CTRL_W-1:0]   frame_control;
    logic [SEQ_BITS-1:0] frame_sequence;
    logic [LEN_W-1:0]    frame_length;
    logic [CHECK_W-1:0]  frame_check;
    logic                start_timer;
  } result_word_t;

endpackage

/* design/sawarq_core.sv */
// Input register, protocol state and per-word decision logic of the ARQ sender.
module sawarq_core import sawarq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         retry_limit_we,
  input  logic [7:0]   retry_limit_data,
  input  logic         item_valid,
  output logic         item_ready,
  input  item_word_t   item,
  output logic         res_push,
  input  logic         res_ready,
  output result_word_t res_word
);

  logic                in_v;
  item_word_t          in_word;
  logic [RETRY_W-1:0]  retry_limit;

  logic [SEQ_BITS-1:0] sequence_number, sequence_number_next;
  logic [RETRY_W-1:0]  retry_count, retry_count_next;
  logic [CHECK_W-1:0]  check_accumulator, check_accumulator_next;
  logic [LEN_W-1:0]    byte_count, byte_count_next;
  logic                awaiting_ack, awaiting_ack_next;

  logic                fire;
  logic                room;
  logic [CHECK_W-1:0]  check_added;
  logic [LEN_W-1:0]    count_added;

  assign fire       = in_v && res_ready;
  assign item_ready = !in_v || res_ready;

  // Hold the incoming word until the result side can take its outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (item_ready) begin
      in_v <= item_valid;
    end
    if (item_valid && item_ready) begin
      in_word <= item;
    end
  end

  // Retry limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (retry_limit_we) begin
      retry_limit <= retry_limit_data;
    end
  end

  // Accumulate a payload byte unless the frame is already full
  assign room        = byte_count < LEN_W'(MAX_PAYLOAD);
  assign check_added = room ? (check_accumulator ^ in_word.payload_byte) : check_accumulator;
  assign count_added = room ? (byte_count + LEN_W'(1)) : byte_count;

  // Decide the outcome of the held word
  always_comb begin
    sequence_number_next   = sequence_number;
    retry_count_next       = retry_count;
    check_accumulator_next = check_accumulator;
    byte_count_next        = byte_count;
    awaiting_ack_next      = awaiting_ack;
    res_push               = 1'b0;
    res_word.action         = ACT_SEND;
    res_word.frame_control  = CTRL_DATA;
    res_word.frame_sequence = sequence_number;
    res_word.frame_length   = byte_count;
    res_word.frame_check    = check_accumulator;
    res_word.start_timer    = 1'b0;
    if (fire) begin
      if (!awaiting_ack) begin
        if (in_word.operation == OP_PAYLOAD) begin
          check_accumulator_next = check_added;
          byte_count_next        = count_added;
          if (in_word.last_of_message) begin
            awaiting_ack_next     = 1'b1;
            retry_count_next      = '0;
            res_push              = 1'b1;
            res_word.action       = ACT_SEND;
            res_word.frame_length = count_added;
            res_word.frame_check  = check_added;
            res_word.start_timer  = 1'b1;
          end
        end
      end else begin
        case (in_word.operation)
          OP_ACK: begin
            if (in_word.ack_sequence == sequence_number) begin
              if (in_word.ack_control == CTRL_ACK) begin
                res_push               = 1'b1;
                res_word.action        = ACT_DELIVERED;
                sequence_number_next   = sequence_number + SEQ_BITS'(1);
                check_accumulator_next = '0;
                byte_count_next        = '0;
                retry_count_next       = '0;
                awaiting_ack_next      = 1'b0;
              end else if (in_word.ack_control == CTRL_NAK) begin
                res_push             = 1'b1;
                res_word.action      = ACT_RETRANSMIT;
                res_word.start_timer = 1'b1;
                retry_count_next     = '0;
              end
            end
          end
          OP_TIMER: begin
            res_push = 1'b1;
            if (retry_count >= retry_limit) begin
              res_word.action        = ACT_GIVE_UP;
              check_accumulator_next = '0;
              byte_count_next        = '0;
              retry_count_next       = '0;
              awaiting_ack_next      = 1'b0;
            end else begin
              res_word.action      = ACT_RETRANSMIT;
              res_word.start_timer = 1'b1;
              retry_count_next     = retry_count + RETRY_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Advance the protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number   <= '0;
      retry_count       <= '0;
      check_accumulator <= '0;
      byte_count        <= '0;
      awaiting_ack      <= 1'b0;
    end else begin
      sequence_number   <= sequence_number_next;
      retry_count       <= retry_count_next;
      check_accumulator <= check_accumulator_next;
      byte_count        <= byte_count_next;
      awaiting_ack      <= awaiting_ack_next;
    end
  end

  // A sent frame leaves the sender waiting for its acknowledgement
  a_send_waits: assert property (@(posedge clk) disable iff (rst)
    res_push && res_word.action == ACT_SEND |=> awaiting_ack)
    else $error("send did not enter the waiting state");

  // Delivery or give-up returns to idle with an empty frame
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    res_push && (res_word.action == ACT_DELIVERED || res_word.action == ACT_GIVE_UP)
    |=> !awaiting_ack && byte_count == '0 && check_accumulator == '0)
    else $error("frame not cleared after close");

  // The frame length never passes the payload limit
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LEN_W'(MAX_PAYLOAD))
    else $error("byte count beyond payload limit");

endmodule

/* design/sawarq_skid.sv */
// Result register with a spare slot so the sender keeps taking words under stall.
module sawarq_skid import sawarq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         push_ready,
  input  result_word_t push_word,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  logic         spare_v;
  result_word_t spare;
  logic         pop;

  assign push_ready = !spare_v;
  assign pop        = result_valid && result_ready;

  // Refill from the spare slot first, then from a new word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_v      <= 1'b0;
    end else if (pop) begin
      if (spare_v) begin
        spare_v <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push && push_ready && result_valid) begin
      spare_v <= 1'b1;
    end else if (push && push_ready) begin
      result_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && spare_v) begin
      result <= spare;
    end else if (push && push_ready && (pop || !result_valid)) begin
      result <= push_word;
    end
    if (push && push_ready && result_valid && !pop) begin
      spare <= push_word;
    end
  end

  // The spare slot fills only behind a waiting result
  a_spare_behind: assert property (@(posedge clk) disable iff (rst)
    spare_v |-> result_valid)
    else $error("spare word without a result word");

  // A pop with a spare word keeps the output valid
  a_spare_refill: assert property (@(posedge clk) disable iff (rst)
    pop && spare_v |=> result_valid && !spare_v)
    else $error("spare word lost on pop");

endmodule

/* design/stop_and_wait_arq_sender.sv */
// Top level of the stop-and-wait ARQ sender.
// Stop-and-wait ARQ transmitter: words on the item channel carry payload bytes,
// received acknowledgements and timer expiries; the result channel returns at
// most one word per item (send, delivered, retransmit or give up, with the frame
// header and a timer start flag). One item is taken every cycle: each item sits
// in the input register, where the protocol state is updated and its outcome
// decided, and its result is then held in a two-word output register, so the
// block stalls only when both output words wait. retry_limit_we writes the
// retry limit (reset 15) and should be used only while the block is idle.
module stop_and_wait_arq_sender import sawarq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         retry_limit_we,
  input  logic [7:0]   retry_limit_data,
  input  logic         item_valid,
  output logic         item_ready,
  input  item_word_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  logic         res_push;
  logic         res_ready;
  result_word_t res_word;

  sawarq_core u_core (
    .clk              (clk),
    .rst              (rst),
    .retry_limit_we   (retry_limit_we),
    .retry_limit_data (retry_limit_data),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item             (item),
    .res_push         (res_push),
    .res_ready        (res_ready),
    .res_word         (res_word)
  );

  sawarq_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (res_push),
    .push_ready   (res_ready),
    .push_word    (res_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
